// ===== hdl/lse_pkg.sv =====
package lse_pkg;

   localparam int NUM_SPECIES  = 4;
   localparam int SPECIES_W    = 2;
   localparam int DIAM_W       = 18;
   localparam int MODE_W       = 18;
   localparam int SPREAD_W     = 16;
   localparam int XMAG_W       = 16;
   localparam int EFFECT_W     = 17;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 18;

   localparam int FRAC_W       = 16;
   localparam int EXP_W        = 5;
   localparam int LOG_W        = EXP_W + FRAC_W;
   localparam int MANT_W       = 32;
   localparam int LN_W         = 20;
   localparam int L_SHIFT      = 12;
   localparam int QUO_W        = 20;
   localparam int Z_SHIFT      = 17;
   localparam int Z_W          = 2 * QUO_W - Z_SHIFT;
   localparam int T_W          = 21;
   localparam int N_W          = T_W - FRAC_W;
   localparam int Y_W          = 32;
   localparam int TERM_W       = 32;
   localparam int SUM_W        = TERM_W + 2;
   localparam int TAYLOR_TERMS = 12;
   localparam int K_W          = $clog2(TAYLOR_TERMS + 1);
   localparam int SHIFT_BASE   = 17;

   localparam logic [FRAC_W-1:0]   LN2_Q16      = 16'd45426;
   localparam logic [FRAC_W:0]     LOG2E_Q16    = 17'd94548;
   localparam logic [Y_W-1:0]      LN2_Q32      = 32'd2977044472;
   localparam logic [FRAC_W-1:0]   ROUND_HALF   = 16'd32768;
   localparam logic [Z_W-1:0]      Z_LIMIT      = Z_W'(12 << FRAC_W);
   localparam logic [EFFECT_W-1:0] ONE_Q16      = 17'd65536;
   localparam logic [MODE_W-1:0]   MODE_RESET   = 18'd256;
   localparam logic [SPREAD_W-1:0] SPREAD_RESET = 16'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE0   = 4'd0,
      CSR_MODE1   = 4'd1,
      CSR_MODE2   = 4'd2,
      CSR_MODE3   = 4'd3,
      CSR_SPREAD0 = 4'd4,
      CSR_SPREAD1 = 4'd5,
      CSR_SPREAD2 = 4'd6,
      CSR_SPREAD3 = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [DIAM_W-1:0] diameter;
      logic [MODE_W-1:0] mode;
      logic [XMAG_W-1:0] xmag;
   } lse_log_in_type;

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [XMAG_W-1:0] xmag;
      logic [LOG_W-1:0]  ld;
      logic [LOG_W-1:0]  lx;
   } lse_log_out_type;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [QUO_W-1:0] q;
   } lse_quo_type;

   typedef struct packed {
      logic                valid;
      logic [EFFECT_W-1:0] effect;
   } lse_res_type;

endpackage

// ===== hdl/lse_if.sv =====
interface lse_req_if;
   import lse_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SPECIES_W-1:0] species_index;
   logic [DIAM_W-1:0]    diameter;
   modport source (output valid, output species_index, output diameter, input ready);
   modport sink (input valid, input species_index, input diameter, output ready);
endinterface

interface lse_rsp_if;
   import lse_pkg::*;
   logic                valid;
   logic                ready;
   logic [EFFECT_W-1:0] effect;
   modport source (output valid, output effect, input ready);
   modport sink (input valid, input effect, output ready);
endinterface

interface lse_csr_if;
   import lse_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lognormal_size_effect_unit.sv =====
// Lognormal size effect: effect = exp(-0.5 * (ln(d / x0) / xb)^2), unsigned Q1.16, clamped to 1.0.
// Channels:
//   req_bus  request: species_index (2 bits) and diameter (unsigned Q10.8).
//   rsp_bus  response: effect (17 bits, 65536 = 1.0), one per request, in order.
//   csr_bus  register writes: index 0..3 mode x0 per species (Q10.8),
//            index 4..7 spread xb per species (signed Q4.12); other indexes ignored.
//            Always ready; write only while no request is in flight.
// Throughput: one request per cycle, sustained while no response waits on rsp_bus.ready.
// Depth: 77 register stages, set by two 16-step log2 squaring chains, a 20-step
//   restoring divider, and a Taylor series whose 11 terms after the first take
//   three stages each.
// Stall: the whole pipeline holds while a response waits on rsp_bus.ready;
//   req_bus.ready drops for that time and nothing in flight is lost.
// Reset: clears all stage valid bits and loads mode = 1.0 and spread = 1.0
//   for every species.
module lognormal_size_effect_unit (
   input logic     clock,
   input logic     reset,
   lse_req_if.sink   req_bus,
   lse_rsp_if.source rsp_bus,
   lse_csr_if.sink   csr_bus
);
   import lse_pkg::*;

   logic [NUM_SPECIES-1:0][MODE_W-1:0]   mode_ff;
   logic [NUM_SPECIES-1:0][SPREAD_W-1:0] spread_ff;

   lse_log_in_type  in_ff;
   lse_log_in_type  in_in;
   lse_log_out_type log_out;
   lse_quo_type     quo_out;
   lse_res_type     res_out;
   logic            advance;
   logic [MODE_W-1:0]   x0;
   logic [SPREAD_W-1:0] xb;

   assign advance       = !res_out.valid || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SPECIES; i++) begin
            mode_ff[i]   <= MODE_RESET;
            spread_ff[i] <= SPREAD_RESET;
         end
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MODE0:   mode_ff[0]   <= csr_bus.data[MODE_W-1:0];
            CSR_MODE1:   mode_ff[1]   <= csr_bus.data[MODE_W-1:0];
            CSR_MODE2:   mode_ff[2]   <= csr_bus.data[MODE_W-1:0];
            CSR_MODE3:   mode_ff[3]   <= csr_bus.data[MODE_W-1:0];
            CSR_SPREAD0: spread_ff[0] <= csr_bus.data[SPREAD_W-1:0];
            CSR_SPREAD1: spread_ff[1] <= csr_bus.data[SPREAD_W-1:0];
            CSR_SPREAD2: spread_ff[2] <= csr_bus.data[SPREAD_W-1:0];
            CSR_SPREAD3: spread_ff[3] <= csr_bus.data[SPREAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      x0             = mode_ff[req_bus.species_index];
      xb             = spread_ff[req_bus.species_index];
      in_in.valid    = req_bus.valid;
      in_in.zero     = (req_bus.diameter == '0) || (x0 == '0) || (xb == '0);
      in_in.diameter = req_bus.diameter;
      in_in.mode     = x0;
      in_in.xmag     = xb[SPREAD_W-1] ? XMAG_W'(~xb + SPREAD_W'(1)) : XMAG_W'(xb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff <= '0;
      end else if (advance) begin
         in_ff <= in_in;
      end
   end

   lse_log u_log (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_data  (in_ff),
      .out_data (log_out)
   );

   lse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_data  (log_out),
      .out_data (quo_out)
   );

   lse_exp u_exp (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_data  (quo_out),
      .out_data (res_out)
   );

   assign rsp_bus.valid  = res_out.valid;
   assign rsp_bus.effect = res_out.effect;

`ifndef SYNTH
   a_effect_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.effect <= ONE_Q16)
      else $error("effect above 1.0");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("response valid right after reset");

   a_csr_ignored: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.ready && csr_bus.index > CSR_SPREAD3)
      |=> ($stable(mode_ff) && $stable(spread_ff)))
      else $error("write to unused register index changed a register");
`endif

endmodule

// ===== hdl/lse_log.sv =====
module lse_log (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  lse_pkg::lse_log_in_type  in_data,
   output lse_pkg::lse_log_out_type out_data
);
   import lse_pkg::*;

   localparam int STEPS = FRAC_W;

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [XMAG_W-1:0] xmag;
      logic [EXP_W-1:0]  pd;
      logic [EXP_W-1:0]  px;
      logic [MANT_W-1:0] md;
      logic [MANT_W-1:0] mx;
      logic [FRAC_W-1:0] fd;
      logic [FRAC_W-1:0] fx;
   } log_stage_type;

   log_stage_type stg_ff [0:STEPS];
   log_stage_type stg_in [0:STEPS];

   function automatic logic [EXP_W-1:0] top_bit(input logic [DIAM_W-1:0] v);
      logic [EXP_W-1:0] p;
      p = '0;
      for (int i = 0; i < DIAM_W; i++) begin
         if (v[i]) p = EXP_W'(i);
      end
      return p;
   endfunction

   function automatic logic [MANT_W-1:0] norm(input logic [DIAM_W-1:0] v,
                                              input logic [EXP_W-1:0] p);
      return MANT_W'(v) << (EXP_W'(MANT_W - 1) - p);
   endfunction

   // mantissa squared, renormalized; top bit is the next fraction bit
   function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
      logic [2*MANT_W-1:0] prod;
      prod = (2*MANT_W)'(m) * (2*MANT_W)'(m);
      if (prod[2*MANT_W-1]) return {1'b1, prod[2*MANT_W-1:MANT_W]};
      else return {1'b0, prod[2*MANT_W-2:MANT_W-1]};
   endfunction

   function automatic log_stage_type first_stage(input lse_log_in_type s);
      log_stage_type r;
      r.valid = s.valid;
      r.zero  = s.zero;
      r.xmag  = s.xmag;
      r.pd    = top_bit(s.diameter);
      r.px    = top_bit(s.mode);
      r.md    = norm(s.diameter, r.pd);
      r.mx    = norm(s.mode, r.px);
      r.fd    = '0;
      r.fx    = '0;
      return r;
   endfunction

   function automatic log_stage_type square_stage(input log_stage_type s);
      log_stage_type   r;
      logic [MANT_W:0] sd;
      logic [MANT_W:0] sx;
      r    = s;
      sd   = sq_step(s.md);
      sx   = sq_step(s.mx);
      r.md = sd[MANT_W-1:0];
      r.mx = sx[MANT_W-1:0];
      r.fd = {s.fd[FRAC_W-2:0], sd[MANT_W]};
      r.fx = {s.fx[FRAC_W-2:0], sx[MANT_W]};
      return r;
   endfunction

   assign stg_in[0] = first_stage(in_data);

   for (genvar i = 1; i <= STEPS; i++) begin : g_sq
      assign stg_in[i] = square_stage(stg_ff[i-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STEPS; i++) stg_ff[i] <= '0;
      end else if (advance) begin
         stg_ff <= stg_in;
      end
   end

   always_comb begin
      out_data.valid = stg_ff[STEPS].valid;
      out_data.zero  = stg_ff[STEPS].zero;
      out_data.xmag  = stg_ff[STEPS].xmag;
      out_data.ld    = {stg_ff[STEPS].pd, stg_ff[STEPS].fd};
      out_data.lx    = {stg_ff[STEPS].px, stg_ff[STEPS].fx};
   end

endmodule

// ===== hdl/lse_div.sv =====
module lse_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  lse_pkg::lse_log_out_type in_data,
   output lse_pkg::lse_quo_type     out_data
);
   import lse_pkg::*;

   localparam int PROD_W = LOG_W + FRAC_W;
   localparam int TOP_SH = QUO_W - L_SHIFT;

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [XMAG_W-1:0] xmag;
      logic [LN_W-1:0]   l;
   } ln_stage_type;

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [XMAG_W-1:0] xmag;
      logic [XMAG_W-1:0] rem;
      logic [QUO_W-1:0]  sh;
   } div_stage_type;

   ln_stage_type  ln_ff;
   ln_stage_type  ln_in;
   div_stage_type div_ff [0:QUO_W];
   div_stage_type div_in [0:QUO_W];

   function automatic ln_stage_type ln_stage(input lse_log_out_type s);
      ln_stage_type      r;
      logic [LOG_W-1:0]  a;
      logic [PROD_W-1:0] prod;
      a      = (s.ld >= s.lx) ? s.ld - s.lx : s.lx - s.ld;
      prod   = PROD_W'(a) * PROD_W'(LN2_Q16) + PROD_W'(ROUND_HALF);
      r.valid = s.valid;
      r.zero  = s.zero;
      r.xmag  = s.xmag;
      r.l     = prod[FRAC_W +: LN_W];
      return r;
   endfunction

   // quotient at or above 2^QUO_W means the effect underflows to zero
   function automatic div_stage_type setup_stage(input ln_stage_type s);
      div_stage_type r;
      logic          ovf;
      ovf     = (XMAG_W + TOP_SH)'(s.l) >= {s.xmag, {TOP_SH{1'b0}}};
      r.valid = s.valid;
      r.zero  = s.zero | ovf;
      r.xmag  = s.xmag;
      r.rem   = XMAG_W'(s.l >> TOP_SH);
      r.sh    = QUO_W'({s.l, {L_SHIFT{1'b0}}});
      return r;
   endfunction

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type     r;
      logic [XMAG_W:0]   r2;
      logic              b;
      r  = s;
      r2 = {s.rem, s.sh[QUO_W-1]};
      if (r2 >= (XMAG_W + 1)'(s.xmag)) begin
         r.rem = XMAG_W'(r2 - (XMAG_W + 1)'(s.xmag));
         b     = 1'b1;
      end else begin
         r.rem = r2[XMAG_W-1:0];
         b     = 1'b0;
      end
      r.sh = {s.sh[QUO_W-2:0], b};
      return r;
   endfunction

   assign ln_in     = ln_stage(in_data);
   assign div_in[0] = setup_stage(ln_ff);

   for (genvar i = 1; i <= QUO_W; i++) begin : g_div
      assign div_in[i] = div_step(div_ff[i-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ln_ff <= '0;
         for (int i = 0; i <= QUO_W; i++) div_ff[i] <= '0;
      end else if (advance) begin
         ln_ff  <= ln_in;
         div_ff <= div_in;
      end
   end

   always_comb begin
      out_data.valid = div_ff[QUO_W].valid;
      out_data.zero  = div_ff[QUO_W].zero;
      out_data.q     = div_ff[QUO_W].sh;
   end

endmodule

// ===== hdl/lse_exp.sv =====
module lse_exp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  lse_pkg::lse_quo_type in_data,
   output lse_pkg::lse_res_type out_data
);
   import lse_pkg::*;

   localparam int TAY_STAGES = 3 * (TAYLOR_TERMS - 1);
   localparam int T_PROD_W   = Z_W + FRAC_W + 1;
   localparam int Y_PROD_W   = FRAC_W + 1 + Y_W;
   localparam int QK_W       = TERM_W + K_W;
   localparam int S_W        = N_W + 1;
   localparam int RND_W      = 2**N_W + SHIFT_BASE + 1;

   typedef struct packed {
      logic           valid;
      logic           zero;
      logic [Z_W-1:0] z;
   } sq_stage_type;

   typedef struct packed {
      logic           valid;
      logic           zero;
      logic [T_W-1:0] t;
   } t_stage_type;

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [N_W-1:0]    n;
      logic [Y_W-1:0]    y;
      logic [SUM_W-1:0]  sum;
      logic [TERM_W-1:0] val;
      logic [TERM_W-1:0] aux;
   } tay_stage_type;

   sq_stage_type  sq_ff;
   sq_stage_type  sq_in;
   t_stage_type   t_ff;
   t_stage_type   t_in;
   tay_stage_type tay_ff [0:TAY_STAGES];
   tay_stage_type tay_in [0:TAY_STAGES];
   lse_res_type   res_ff;
   lse_res_type   res_in;

   function automatic sq_stage_type sq_stage(input lse_quo_type s);
      sq_stage_type       r;
      logic [2*QUO_W-1:0] prod;
      prod    = (2*QUO_W)'(s.q) * (2*QUO_W)'(s.q);
      r.valid = s.valid;
      r.zero  = s.zero;
      r.z     = prod[2*QUO_W-1:Z_SHIFT];
      return r;
   endfunction

   function automatic t_stage_type t_stage(input sq_stage_type s);
      t_stage_type         r;
      logic [T_PROD_W-1:0] prod;
      prod    = T_PROD_W'(s.z) * T_PROD_W'(LOG2E_Q16) + T_PROD_W'(ROUND_HALF);
      r.valid = s.valid;
      r.zero  = s.zero | (s.z >= Z_LIMIT);
      r.t     = prod[FRAC_W +: T_W];
      return r;
   endfunction

   // first Taylor term is y itself
   function automatic tay_stage_type y_stage(input t_stage_type s);
      tay_stage_type       r;
      logic [FRAC_W:0]     g;
      logic [Y_PROD_W-1:0] prod;
      g       = ONE_Q16 - (FRAC_W + 1)'(s.t[FRAC_W-1:0]);
      prod    = Y_PROD_W'(g) * Y_PROD_W'(LN2_Q32);
      r.valid = s.valid;
      r.zero  = s.zero;
      r.n     = s.t[T_W-1:FRAC_W];
      r.y     = prod[FRAC_W +: Y_W];
      r.val   = prod[FRAC_W +: Y_W];
      r.sum   = (SUM_W'(1) << TERM_W) + SUM_W'(prod[FRAC_W +: Y_W]);
      r.aux   = '0;
      return r;
   endfunction

   function automatic tay_stage_type tay_mul(input tay_stage_type s);
      tay_stage_type       r;
      logic [2*TERM_W-1:0] prod;
      r     = s;
      prod  = (2*TERM_W)'(s.val) * (2*TERM_W)'(s.y);
      r.val = prod[2*TERM_W-1:TERM_W];
      return r;
   endfunction

   function automatic tay_stage_type tay_rcp(input tay_stage_type s,
                                             input logic [TERM_W-1:0] recip);
      tay_stage_type       r;
      logic [2*TERM_W-1:0] prod;
      r     = s;
      prod  = (2*TERM_W)'(s.val) * (2*TERM_W)'(recip);
      r.aux = s.val;
      r.val = prod[2*TERM_W-1:TERM_W];
      return r;
   endfunction

   // reciprocal estimate is low by at most one
   function automatic tay_stage_type tay_fix(input tay_stage_type s,
                                             input logic [K_W-1:0] k);
      tay_stage_type     r;
      logic [QK_W-1:0]   qk;
      logic [QK_W-1:0]   rem;
      logic [TERM_W-1:0] term;
      r     = s;
      qk    = QK_W'(s.val) * QK_W'(k);
      rem   = QK_W'(s.aux) - qk;
      term  = (rem >= QK_W'(k)) ? s.val + TERM_W'(1) : s.val;
      r.val = term;
      r.sum = s.sum + SUM_W'(term);
      return r;
   endfunction

   function automatic lse_res_type out_stage(input tay_stage_type s);
      lse_res_type      r;
      logic [S_W-1:0]   sh;
      logic [RND_W-1:0] rnd;
      logic [RND_W-1:0] v;
      sh      = S_W'(s.n) + S_W'(SHIFT_BASE);
      rnd     = RND_W'(s.sum) + (RND_W'(1) << (sh - S_W'(1)));
      v       = rnd >> sh;
      r.valid = s.valid;
      if (s.zero) r.effect = '0;
      else if (v > RND_W'(ONE_Q16)) r.effect = ONE_Q16;
      else r.effect = v[EFFECT_W-1:0];
      return r;
   endfunction

   assign sq_in     = sq_stage(in_data);
   assign t_in      = t_stage(sq_ff);
   assign tay_in[0] = y_stage(t_ff);

   for (genvar j = 0; j < TAYLOR_TERMS - 1; j++) begin : g_term
      localparam logic [K_W-1:0]    K     = K_W'(j + 2);
      localparam logic [TERM_W-1:0] RECIP = TERM_W'((64'd1 << TERM_W) / (j + 2));
      assign tay_in[3*j+1] = tay_mul(tay_ff[3*j]);
      assign tay_in[3*j+2] = tay_rcp(tay_ff[3*j+1], RECIP);
      assign tay_in[3*j+3] = tay_fix(tay_ff[3*j+2], K);
   end

   assign res_in = out_stage(tay_ff[TAY_STAGES]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff  <= '0;
         t_ff   <= '0;
         res_ff <= '0;
         for (int i = 0; i <= TAY_STAGES; i++) tay_ff[i] <= '0;
      end else if (advance) begin
         sq_ff  <= sq_in;
         t_ff   <= t_in;
         tay_ff <= tay_in;
         res_ff <= res_in;
      end
   end

   assign out_data = res_ff;

endmodule
